@@ rtl/lzss_window_compressor_assert.svh @@
// assertion macros for the lzss window compressor
`ifndef LZSS_WINDOW_COMPRESSOR_ASSERT_SVH
`define LZSS_WINDOW_COMPRESSOR_ASSERT_SVH

// implication checked at the same edge
`define LZWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked at the following edge
`define LZWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lzwc_pkg.sv @@
`default_nettype none

package lzwc_pkg;

    // window geometry
    localparam int HIST_LEN    = 1023;
    localparam int LA_DEPTH    = 66;
    localparam int LINE_LEN    = HIST_LEN + LA_DEPTH;
    localparam int GROUP_W     = 32;
    localparam int FLAG_GROUPS = (LINE_LEN + GROUP_W - 1) / GROUP_W;
    localparam int PAD_LEN     = FLAG_GROUPS * GROUP_W;

    // token format
    localparam int GROUP_TOKENS = 8;
    localparam int GROUP_BYTES  = 16;
    localparam int MIN_MATCH    = 3;
    localparam int LOC_BIAS     = 958;

    // command from the front part
    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
    } cmd_t;

    // one byte of the compressed stream
    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
        logic       stream_end;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_START,
        ST_CMP,
        ST_OR,
        ST_DEC,
        ST_FG,
        ST_FI,
        ST_FB,
        ST_TOK,
        ST_SHIFT,
        ST_MASK,
        ST_BYTES
    } eng_state_t;

endpackage

`default_nettype wire

@@ rtl/lzwc_front.sv @@
`default_nettype none

module lzwc_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          func,
    input  wire logic [7:0]    data_byte,
    output logic               cmd_valid,
    input  wire logic          cmd_pop,
    output lzwc_pkg::cmd_t     cmd
);

    lzwc_pkg::cmd_t slot_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;

    // classify and queue items
    assign in_stall  = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].is_end <= func;
            slot_reg[wr_ptr_reg].data   <= data_byte;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lzwc_outq.sv @@
`default_nettype none

module lzwc_outq
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lzwc_pkg::out_t item,
    output logic                full,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          out_byte,
    output logic                last_of_run,
    output logic                stream_end
);

    lzwc_pkg::out_t slot_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    // two-entry skid queue toward the output port
    assign full        = (cnt_reg == 2'd2);
    assign out_valid   = (cnt_reg != 2'd0);
    assign out_byte    = slot_reg[rd_ptr_reg].byte_val;
    assign last_of_run = slot_reg[rd_ptr_reg].last;
    assign stream_end  = slot_reg[rd_ptr_reg].stream_end;
    assign do_push     = push && !full;
    assign do_pop      = out_valid && !out_stall;

    assign cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lzwc_engine.sv @@
`default_nettype none

module lzwc_engine
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_pop,
    input  wire lzwc_pkg::cmd_t cmd,
    output logic                out_push,
    output lzwc_pkg::out_t      out_item,
    input  wire logic           out_full
);

    localparam int HL = lzwc_pkg::HIST_LEN;
    localparam int LD = lzwc_pkg::LA_DEPTH;
    localparam int LL = lzwc_pkg::LINE_LEN;
    localparam int NG = lzwc_pkg::FLAG_GROUPS;
    localparam int GW = lzwc_pkg::GROUP_W;
    localparam int PL = lzwc_pkg::PAD_LEN;

    lzwc_pkg::eng_state_t state_reg;
    lzwc_pkg::eng_state_t state_next;

    // history and lookahead form one shift line, oldest byte at index 0
    logic [7:0] hist_reg  [0:HL-1];
    logic [7:0] la_reg    [0:LD-1];
    logic [7:0] probe_reg [0:LD-1];
    logic [7:0] seq_w     [0:LL-1];
    logic [7:0] gbytes_reg [0:lzwc_pkg::GROUP_BYTES-1];

    logic [LL-1:0] flag_reg;
    logic [LL-1:0] cand_reg;
    logic [LL-1:0] cand_next;
    logic [NG-1:0] grp_reg;
    logic [NG-1:0] grp_next;
    logic [PL-1:0] grp_src;
    logic [PL-1:0] flag_pad;
    logic [GW-1:0] word_w;
    logic [5:0]    grp_sel_reg;
    logic [5:0]    grp_sel_next;
    logic [4:0]    bit_sel;
    logic [10:0]   pos_w;
    logic [10:0]   dist_w;
    logic [9:0]    dist_reg;
    logic [9:0]    loc_w;
    logic [6:0]    count_reg;
    logic [6:0]    len_reg;
    logic [6:0]    consume_reg;
    logic [3:0]    tokens_reg;
    logic [4:0]    fill_reg;
    logic [7:0]    mask_reg;
    logic [3:0]    idx_reg;
    logic          mode_end_reg;
    logic          end_flag_reg;
    logic          any_w;
    logic          is_match;
    logic          last_byte;
    logic          clear_all;
    logic          grp_done;

    assign any_w     = |grp_reg;
    assign is_match  = (len_reg >= 7'(lzwc_pkg::MIN_MATCH));
    assign last_byte = ({1'b0, idx_reg} == (fill_reg - 5'd1));
    assign grp_done  = (state_reg == lzwc_pkg::ST_BYTES) && !out_full && last_byte;
    assign clear_all = (grp_done && end_flag_reg)
                       || ((state_reg == lzwc_pkg::ST_DRAIN) && (count_reg == 7'd0)
                           && (tokens_reg == 4'd0));

    // view of the shift line
    genvar gi;
    generate
        for (gi = 0; gi < LL; gi++)
        begin : g_seq
            if (gi < HL)
            begin : g_h
                assign seq_w[gi] = hist_reg[gi];
            end
            else
            begin : g_l
                assign seq_w[gi] = la_reg[gi - HL];
            end
        end
    endgenerate

    // match flags move one cell per compared byte
    always_comb
    begin
        cand_next[0] = 1'b0;
        for (int p = 0; p < LL - 1; p++)
        begin
            cand_next[p + 1] = flag_reg[p] && (seq_w[p] == probe_reg[0]);
        end
    end

    // first level of the reduction over the candidate row (OR step) or the flag row
    always_comb
    begin
        grp_src  = (state_reg == lzwc_pkg::ST_OR) ? PL'(cand_reg) : PL'(flag_reg);
        flag_pad = PL'(flag_reg);
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = |grp_src[g*GW +: GW];
        end
    end

    // lowest nonzero group holds the oldest surviving candidate
    always_comb
    begin
        grp_sel_next = 6'd0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_reg[g])
            begin
                grp_sel_next = 6'(g);
            end
        end
    end

    // lowest flag inside the chosen group, then the distance
    always_comb
    begin
        word_w  = flag_pad[grp_sel_reg*GW +: GW];
        bit_sel = 5'd0;
        for (int b = GW - 1; b >= 0; b--)
        begin
            if (word_w[b])
            begin
                bit_sel = 5'(b);
            end
        end
        pos_w  = {grp_sel_reg, bit_sel};
        dist_w = 11'(HL) - pos_w + {4'd0, len_reg};
        loc_w  = 10'(lzwc_pkg::LOC_BIAS) - dist_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lzwc_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.is_end)
                    begin
                        state_next = lzwc_pkg::ST_DRAIN;
                    end
                    else if (count_reg == 7'(LD - 1))
                    begin
                        state_next = lzwc_pkg::ST_START;
                    end
                end
            end
            lzwc_pkg::ST_DRAIN:
            begin
                if ((count_reg != 7'd0) && (tokens_reg != 4'(lzwc_pkg::GROUP_TOKENS)))
                begin
                    state_next = lzwc_pkg::ST_START;
                end
                else if (tokens_reg != 4'd0)
                begin
                    state_next = lzwc_pkg::ST_MASK;
                end
                else
                begin
                    state_next = lzwc_pkg::ST_IDLE;
                end
            end
            lzwc_pkg::ST_START: state_next = lzwc_pkg::ST_CMP;
            lzwc_pkg::ST_CMP:   state_next = lzwc_pkg::ST_OR;
            lzwc_pkg::ST_OR:    state_next = lzwc_pkg::ST_DEC;
            lzwc_pkg::ST_DEC:
            begin
                if (any_w && ((len_reg + 7'd1) != count_reg))
                begin
                    state_next = lzwc_pkg::ST_CMP;
                end
                else if ((any_w ? len_reg + 7'd1 : len_reg) >= 7'(lzwc_pkg::MIN_MATCH))
                begin
                    state_next = lzwc_pkg::ST_FG;
                end
                else
                begin
                    state_next = lzwc_pkg::ST_TOK;
                end
            end
            lzwc_pkg::ST_FG:    state_next = lzwc_pkg::ST_FI;
            lzwc_pkg::ST_FI:    state_next = lzwc_pkg::ST_FB;
            lzwc_pkg::ST_FB:    state_next = lzwc_pkg::ST_TOK;
            lzwc_pkg::ST_TOK:   state_next = lzwc_pkg::ST_SHIFT;
            lzwc_pkg::ST_SHIFT:
            begin
                if (consume_reg == 7'd1)
                begin
                    if (mode_end_reg)
                    begin
                        state_next = lzwc_pkg::ST_DRAIN;
                    end
                    else if (tokens_reg == 4'(lzwc_pkg::GROUP_TOKENS))
                    begin
                        state_next = lzwc_pkg::ST_MASK;
                    end
                    else
                    begin
                        state_next = lzwc_pkg::ST_IDLE;
                    end
                end
            end
            lzwc_pkg::ST_MASK:
            begin
                if (!out_full)
                begin
                    state_next = lzwc_pkg::ST_BYTES;
                end
            end
            lzwc_pkg::ST_BYTES:
            begin
                if (grp_done)
                begin
                    state_next = lzwc_pkg::ST_IDLE;
                end
            end
            default: state_next = lzwc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_pop  = 1'b0;
        out_push = 1'b0;
        out_item = '0;
        unique case (state_reg)
            lzwc_pkg::ST_IDLE:
            begin
                cmd_pop = cmd_valid;
            end
            lzwc_pkg::ST_MASK:
            begin
                out_push          = !out_full;
                out_item.byte_val = mask_reg;
            end
            lzwc_pkg::ST_BYTES:
            begin
                out_push            = !out_full;
                out_item.byte_val   = gbytes_reg[idx_reg];
                out_item.last       = last_byte;
                out_item.stream_end = last_byte && end_flag_reg;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzwc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // history line: shifts on consume, zeroed at end of stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HL; i++)
            begin
                hist_reg[i] <= 8'd0;
            end
        end
        else if (clear_all)
        begin
            for (int i = 0; i < HL; i++)
            begin
                hist_reg[i] <= 8'd0;
            end
        end
        else if (state_reg == lzwc_pkg::ST_SHIFT)
        begin
            for (int i = 0; i < HL - 1; i++)
            begin
                hist_reg[i] <= hist_reg[i + 1];
            end
            hist_reg[HL - 1] <= la_reg[0];
        end
    end

    // lookahead: written at the fill point, shifts on consume
    always_ff @(posedge clk)
    begin
        if (state_reg == lzwc_pkg::ST_SHIFT)
        begin
            for (int i = 0; i < LD - 1; i++)
            begin
                la_reg[i] <= la_reg[i + 1];
            end
        end
        else if ((state_reg == lzwc_pkg::ST_IDLE) && cmd_valid && !cmd.is_end)
        begin
            la_reg[count_reg] <= cmd.data;
        end
    end

    // search datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            lzwc_pkg::ST_START:
            begin
                flag_reg <= LL'({HL{1'b1}});
                for (int i = 0; i < LD; i++)
                begin
                    probe_reg[i] <= la_reg[i];
                end
            end
            lzwc_pkg::ST_CMP:
            begin
                cand_reg <= cand_next;
            end
            lzwc_pkg::ST_OR, lzwc_pkg::ST_FG:
            begin
                grp_reg <= grp_next;
            end
            lzwc_pkg::ST_DEC:
            begin
                if (any_w)
                begin
                    flag_reg <= cand_reg;
                    for (int i = 0; i < LD - 1; i++)
                    begin
                        probe_reg[i] <= probe_reg[i + 1];
                    end
                end
            end
            lzwc_pkg::ST_FI:
            begin
                grp_sel_reg <= grp_sel_next;
            end
            lzwc_pkg::ST_FB:
            begin
                dist_reg <= dist_w[9:0];
            end
            default:
            begin
                dist_reg <= dist_reg;
            end
        endcase
    end

    // token group bytes
    always_ff @(posedge clk)
    begin
        if (state_reg == lzwc_pkg::ST_TOK)
        begin
            if (is_match)
            begin
                gbytes_reg[fill_reg[3:0]] <= {6'(len_reg - 7'(lzwc_pkg::MIN_MATCH)),
                                              loc_w[9:8]};
                gbytes_reg[fill_reg[3:0] + 4'd1] <= loc_w[7:0];
            end
            else
            begin
                gbytes_reg[fill_reg[3:0]] <= la_reg[0];
            end
        end
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= 7'd0;
            len_reg      <= 7'd0;
            consume_reg  <= 7'd0;
            tokens_reg   <= 4'd0;
            fill_reg     <= 5'd0;
            mask_reg     <= 8'd0;
            idx_reg      <= 4'd0;
            mode_end_reg <= 1'b0;
            end_flag_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                lzwc_pkg::ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        mode_end_reg <= cmd.is_end;
                        end_flag_reg <= 1'b0;
                        if (!cmd.is_end)
                        begin
                            count_reg <= count_reg + 7'd1;
                        end
                    end
                end
                lzwc_pkg::ST_DRAIN:
                begin
                    end_flag_reg <= (count_reg == 7'd0);
                end
                lzwc_pkg::ST_START:
                begin
                    len_reg <= 7'd0;
                end
                lzwc_pkg::ST_DEC:
                begin
                    if (any_w)
                    begin
                        len_reg <= len_reg + 7'd1;
                    end
                end
                lzwc_pkg::ST_TOK:
                begin
                    tokens_reg <= tokens_reg + 4'd1;
                    if (is_match)
                    begin
                        fill_reg    <= fill_reg + 5'd2;
                        consume_reg <= len_reg;
                    end
                    else
                    begin
                        fill_reg    <= fill_reg + 5'd1;
                        consume_reg <= 7'd1;
                        mask_reg    <= mask_reg | (8'd1 << tokens_reg[2:0]);
                    end
                end
                lzwc_pkg::ST_SHIFT:
                begin
                    consume_reg <= consume_reg - 7'd1;
                    count_reg   <= count_reg - 7'd1;
                end
                lzwc_pkg::ST_MASK:
                begin
                    idx_reg <= 4'd0;
                end
                lzwc_pkg::ST_BYTES:
                begin
                    if (!out_full)
                    begin
                        idx_reg <= idx_reg + 4'd1;
                        if (last_byte)
                        begin
                            tokens_reg <= 4'd0;
                            fill_reg   <= 5'd0;
                            mask_reg   <= 8'd0;
                        end
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/lzss_window_compressor.sv @@
// Greedy LZSS compressor, 1023-byte window, 66-byte lookahead. Each transfer
// either pushes one plain byte (func 0) or marks end of data (func 1); the
// compressed stream leaves one byte per transfer as mask, literal and match
// bytes, with last_of_run on the final byte caused by an input and stream_end
// on the final byte of a stream. A push that does not fill the lookahead is only
// stored there, with no search. Each token decision walks a row of 1089 cells
// (1023 history, 66 lookahead) in compare, grouped OR and decide steps per
// compared lookahead byte, then picks the oldest distance for a match in
// group, index and distance steps, builds the token and shifts the line once
// per consumed byte; emitting a group sends the mask byte and the token bytes,
// up to 17 output bytes. Two-entry queues on input and output let the source
// and sink stall independently. History is held in flip-flops and is cleared
// by reset and at end of stream in a single update, so there is no clearing
// pass after reset or end of stream.
`default_nettype none

module lzss_window_compressor
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       func,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            last_of_run,
    output logic            stream_end
);

    lzwc_pkg::cmd_t cmd;
    lzwc_pkg::out_t out_item;
    logic           cmd_valid;
    logic           cmd_pop;
    logic           out_push;
    logic           out_full;

    // front part: accept and queue commands
    lzwc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .data_byte (data_byte),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // back part: search, token build and group emit
    lzwc_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .out_push  (out_push),
        .out_item  (out_item),
        .out_full  (out_full)
    );

    // output skid queue
    lzwc_outq u_outq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (out_push),
        .item        (out_item),
        .full        (out_full),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .stream_end  (stream_end)
    );

endmodule

`default_nettype wire

@@ rtl/lzwc_checker.sv @@
`default_nettype none

`include "lzss_window_compressor_assert.svh"

module lzwc_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       func,
    input wire logic [7:0] data_byte,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       last_of_run,
    input wire logic       stream_end
);

    // end of stream is always the last byte of its run
    `LZWC_ASSERT_NOW(a_end_is_last, out_valid && stream_end, last_of_run, "stream_end without last_of_run")

    // nothing is shown right after reset release
    `LZWC_ASSERT_NOW(a_quiet_after_reset, $rose(rst_n), !out_valid, "output right after reset")

    // a stalled byte stays offered
    `LZWC_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "valid dropped under stall")

    // a stalled byte keeps its value
    `LZWC_ASSERT_NEXT(a_hold_data, out_valid && out_stall, $stable(out_byte) && $stable(last_of_run) && $stable(stream_end), "payload changed under stall")

    // a stalled input transfer keeps its payload
    `LZWC_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(func) && $stable(data_byte), "input changed under stall")

endmodule

bind lzss_window_compressor lzwc_checker u_lzwc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .stream_end  (stream_end)
);

`default_nettype wire
